// ----- hdl/ssg_pkg.sv -----
// shared types, constants and sine table math for the sine sample generator
package ssg_pkg;

    // default sizes
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF      = 20;

    // command queue between front and back, as a power of two
    localparam int QUEUE_DEPTH_BITS = 2;

    // configuration port
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;
    localparam int LIMIT_BITS = 21;

    // register reset values
    localparam logic [31:0]           PHASE_STEP_RST   = 32'd4294967;
    localparam logic [31:0]           PHASE_OFFSET_RST = 32'd0;
    localparam logic signed [15:0]    AMPLITUDE_RST    = 16'sd256;
    localparam logic signed [15:0]    LEVEL_OFFSET_RST = 16'sd0;
    localparam logic [LIMIT_BITS-1:0] SAMPLE_LIMIT_RST = 21'd1001;

    // register indexes (byte address divided by four)
    typedef enum logic [2:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_PHASE_OFFSET = 3'd1,
        REG_AMPLITUDE    = 3'd2,
        REG_LEVEL_OFFSET = 3'd3,
        REG_SAMPLE_LIMIT = 3'd4
    } t_reg_idx;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [31:0]           phase_step;
        logic [31:0]           phase_offset;
        logic signed [15:0]    amplitude;
        logic signed [15:0]    level_offset;
        logic [LIMIT_BITS-1:0] sample_limit;
    } t_cfg;

    // pi/2 in unsigned Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // taylor series divisors (2n)(2n+1) for n = 1..13
    localparam int TAYLOR_TERMS = 13;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // product of two Q62 values, truncated to Q62
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(32767 * sin(x)) for x in [0, pi/2] given in Q62, used at elaboration only
    function automatic logic [14:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int n = 0; n < TAYLOR_TERMS; n++) begin
            term = q62_mul(term, x2) / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = ((sum >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// ----- hdl/ssg_regs.sv -----
// configuration register file behind the apb-style port
module ssg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssg_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [ssg_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [ssg_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    output ssg_pkg::t_cfg                      o_cfg
);

    ssg_pkg::t_cfg     r_cfg;
    ssg_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = ssg_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access cycle of a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= ssg_pkg::PHASE_STEP_RST;
            r_cfg.phase_offset <= ssg_pkg::PHASE_OFFSET_RST;
            r_cfg.amplitude    <= ssg_pkg::AMPLITUDE_RST;
            r_cfg.level_offset <= ssg_pkg::LEVEL_OFFSET_RST;
            r_cfg.sample_limit <= ssg_pkg::SAMPLE_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                ssg_pkg::REG_PHASE_STEP:   r_cfg.phase_step   <= pwdata;
                ssg_pkg::REG_PHASE_OFFSET: r_cfg.phase_offset <= pwdata;
                ssg_pkg::REG_AMPLITUDE:    r_cfg.amplitude    <= pwdata[15:0];
                ssg_pkg::REG_LEVEL_OFFSET: r_cfg.level_offset <= pwdata[15:0];
                ssg_pkg::REG_SAMPLE_LIMIT:
                    r_cfg.sample_limit <= pwdata[ssg_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            ssg_pkg::REG_PHASE_STEP:   prdata = r_cfg.phase_step;
            ssg_pkg::REG_PHASE_OFFSET: prdata = r_cfg.phase_offset;
            ssg_pkg::REG_AMPLITUDE:    prdata = {16'd0, r_cfg.amplitude};
            ssg_pkg::REG_LEVEL_OFFSET: prdata = {16'd0, r_cfg.level_offset};
            ssg_pkg::REG_SAMPLE_LIMIT:
                prdata = {{(ssg_pkg::PDATA_BITS-ssg_pkg::LIMIT_BITS){1'b0}},
                          r_cfg.sample_limit};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- hdl/ssg_queue.sv -----
// small command queue between the phase front end and the sample back end
module ssg_queue #(
    parameter int WIDTH      = 33,
    parameter int DEPTH_BITS = ssg_pkg::QUEUE_DEPTH_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_not_empty
);

    localparam int DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [DEPTH_BITS-1:0] r_wr_ptr;
    logic [DEPTH_BITS-1:0] r_rd_ptr;
    logic [DEPTH_BITS:0]   r_count;

    assign o_head      = r_mem[r_rd_ptr];
    assign o_full      = (r_count == (DEPTH_BITS+1)'(DEPTH));
    assign o_not_empty = (r_count != '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- hdl/ssg_front.sv -----
// front end: accepts ticks, runs the phase accumulator and sample counter
module ssg_front #(
    parameter int PHASE_BITS      = ssg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int COUNT_BITS      = ssg_pkg::COUNT_BITS_DEF,
    parameter int CMD_BITS        = TABLE_ADDR_BITS + COUNT_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssg_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic                i_restart,
    output logic                o_stall,
    input  logic                i_queue_full,
    output logic                o_push,
    output logic [CMD_BITS-1:0] o_push_data
);

    localparam int DONE_BITS = COUNT_BITS + 1;
    localparam int CMP_BITS  = (DONE_BITS > ssg_pkg::LIMIT_BITS) ? DONE_BITS
                                                                 : ssg_pkg::LIMIT_BITS;

    logic [PHASE_BITS-1:0] r_phase;
    logic [DONE_BITS-1:0]  r_done;
    logic [PHASE_BITS-1:0] n_phase;
    logic [DONE_BITS-1:0]  n_done;
    logic [PHASE_BITS-1:0] w_phase;
    logic [DONE_BITS-1:0]  w_done;
    logic [PHASE_BITS-1:0] w_look;
    logic [CMP_BITS-1:0]   w_done_ext;
    logic [CMP_BITS-1:0]   w_limit_ext;
    logic                  w_emit;
    logic                  w_last;
    logic                  w_accept;

    assign o_stall  = i_queue_full;
    assign w_accept = i_valid && !i_queue_full;

    // restart clears the run before this tick's sample
    assign w_phase = i_restart ? '0 : r_phase;
    assign w_done  = i_restart ? '0 : r_done;

    // run limit and last-sample checks
    assign w_done_ext  = CMP_BITS'(w_done);
    assign w_limit_ext = CMP_BITS'(i_cfg.sample_limit);
    assign w_emit      = (w_done_ext < w_limit_ext);
    assign w_last      = ((w_done_ext + 1'b1) == w_limit_ext);

    // table address from the top of the offset phase
    assign w_look = w_phase + PHASE_BITS'(i_cfg.phase_offset);

    assign o_push      = w_accept && w_emit;
    assign o_push_data = {w_look[PHASE_BITS-1 -: TABLE_ADDR_BITS],
                          w_done[COUNT_BITS-1:0], w_last};

    // next state: advance only when a sample is made
    always_comb begin
        if (w_emit) begin
            n_phase = w_phase + PHASE_BITS'(i_cfg.phase_step);
            n_done  = w_done + 1'b1;
        end else begin
            n_phase = w_phase;
            n_done  = w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_done  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

endmodule

// ----- hdl/ssg_back.sv -----
// back end: quarter-wave sine rom, amplitude multiply, level offset, output register
module ssg_back #(
    parameter int TABLE_ADDR_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int COUNT_BITS      = ssg_pkg::COUNT_BITS_DEF,
    parameter int CMD_BITS        = TABLE_ADDR_BITS + COUNT_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ssg_pkg::t_cfg          i_cfg,
    input  logic [CMD_BITS-1:0]    i_head,
    input  logic                   i_not_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [23:0]     o_sample_value,
    output logic [COUNT_BITS-1:0]  o_sample_index,
    output logic                   o_last
);

    localparam int QUARTER  = 1 << (TABLE_ADDR_BITS - 2);
    localparam int ROM_BITS = TABLE_ADDR_BITS - 1;

    typedef logic [14:0] t_quarter [0:QUARTER];

    // quarter wave of round(32767*sin), built at elaboration
    function automatic t_quarter build_quarter();
        t_quarter    t;
        logic [63:0] unit;
        unit = ssg_pkg::HALF_PI_Q62 >> (TABLE_ADDR_BITS - 2);
        for (int k = 0; k <= QUARTER; k++) begin
            t[k] = ssg_pkg::quarter_sine(unit * 64'(k));
        end
        return t;
    endfunction

    localparam t_quarter SINE_ROM = build_quarter();

    logic [TABLE_ADDR_BITS-1:0] w_addr;
    logic [COUNT_BITS-1:0]      w_index;
    logic                       w_last;
    logic [ROM_BITS-1:0]        w_rom_idx;
    logic                       w_adv;

    logic                       r_v1;
    logic [14:0]                r_rom;
    logic                       r_neg1;
    logic [COUNT_BITS-1:0]      r_index1;
    logic                       r_last1;

    logic                       r_v2;
    logic signed [15:0]         w_sine;
    logic signed [31:0]         n_prod;
    logic signed [31:0]         r_prod;
    logic [COUNT_BITS-1:0]      r_index2;
    logic                       r_last2;

    logic                       r_v3;
    logic signed [31:0]         w_shift;
    logic signed [23:0]         n_value;

    assign {w_addr, w_index, w_last} = i_head;

    // the whole pipeline moves together unless the output is held
    assign w_adv = !r_v3 || !i_stall;
    assign o_pop = w_adv && i_not_empty;

    // fold the address into the first quadrant
    assign w_rom_idx = w_addr[TABLE_ADDR_BITS-2]
                     ? ROM_BITS'(QUARTER) - {1'b0, w_addr[TABLE_ADDR_BITS-3:0]}
                     : {1'b0, w_addr[TABLE_ADDR_BITS-3:0]};

    // signed table value times amplitude
    assign w_sine = r_neg1 ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});
    assign n_prod = w_sine * i_cfg.amplitude;

    // floor shift by 15 then level offset
    assign w_shift = r_prod >>> 15;
    assign n_value = w_shift[23:0]
                   + {{8{i_cfg.level_offset[15]}}, i_cfg.level_offset};

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_not_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage payloads, rom read registered
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rom          <= SINE_ROM[w_rom_idx];
            r_neg1         <= w_addr[TABLE_ADDR_BITS-1];
            r_index1       <= w_index;
            r_last1        <= w_last;
            r_prod         <= n_prod;
            r_index2       <= r_index1;
            r_last2        <= r_last1;
            o_sample_value <= n_value;
            o_sample_index <= r_index2;
            o_last         <= r_last2;
        end
    end

    assign o_valid = r_v3;

endmodule

// ----- hdl/sine_sample_generator_core.sv -----
// top level of the direct digital synthesis sine sample generator
// Each accepted tick makes at most one sample, amplitude*sin(phase+offset)+level, of a run
// of sample_limit samples; restart starts a new run at sample zero. The block takes one
// tick per clock unless its input is stalled: the only loop is the phase accumulator and
// sample counter in the front end, one add each. Ticks go into a four-entry command queue;
// the back end reads the quarter-wave sine rom, multiplies by the amplitude and adds the
// level offset, with the rom read, the product and the output sample each registered.
// Input stall rises only when the queue is full, which can happen only while the output is
// stalled. Ticks past the end of a run are accepted and give no sample.
// The sine table is a constant rom of 2^(TABLE_ADDR_BITS-2)+1 entries; no clearing pass is
// needed after reset.
module sine_sample_generator_core #(
    parameter int PHASE_BITS      = ssg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = ssg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int COUNT_BITS      = ssg_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_restart,
    // sample channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [23:0]                o_sample_value,
    output logic [COUNT_BITS-1:0]             o_sample_index,
    output logic                              o_last,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssg_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ssg_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [ssg_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);

    localparam int CMD_BITS = TABLE_ADDR_BITS + COUNT_BITS + 1;

    ssg_pkg::t_cfg       w_cfg;
    logic                w_push;
    logic [CMD_BITS-1:0] w_push_data;
    logic                w_pop;
    logic [CMD_BITS-1:0] w_head;
    logic                w_full;
    logic                w_not_empty;

    // configuration registers
    ssg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // phase accumulator and run counter
    ssg_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS),
        .CMD_BITS        (CMD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .i_restart    (i_restart),
        .o_stall      (o_stall),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // command queue
    ssg_queue #(
        .WIDTH      (CMD_BITS),
        .DEPTH_BITS (ssg_pkg::QUEUE_DEPTH_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_full      (w_full),
        .o_not_empty (w_not_empty)
    );

    // sine lookup and scaling
    ssg_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS),
        .CMD_BITS        (CMD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_head         (w_head),
        .i_not_empty    (w_not_empty),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_last         (o_last)
    );

endmodule

// ----- bench/tb_sine_sample_generator_core.sv -----
// self-checking testbench for the sine sample generator core
`timescale 1ns / 100ps

module tb_sine_sample_generator_core;

    localparam int COUNT_BITS     = ssg_pkg::COUNT_BITS_DEF;
    localparam int TABLE_BITS     = ssg_pkg::TABLE_ADDR_BITS_DEF;
    localparam int TABLE_SIZE     = 1 << TABLE_BITS;
    localparam int QUARTER        = TABLE_SIZE / 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_TARGET  = 1550;
    localparam int PHASE_SAMPLES  = 130;
    localparam int IDLE_PERCENT   = 7;
    localparam real HALF_PI       = 1.57079632679489661923;
    localparam longint WATCHDOG_NS = 20_000_000;

    // register indexes outside the map, writes there must be dropped
    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [23:0]    value;
        logic [COUNT_BITS-1:0] index;
        logic                  last;
    } t_sample;

    // block ports
    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_valid   = 1'b0;
    logic                   o_stall;
    logic                   i_restart = 1'b0;
    logic                   o_valid;
    logic                   i_stall   = 1'b0;
    logic signed [23:0]     o_sample_value;
    logic [COUNT_BITS-1:0]  o_sample_index;
    logic                   o_last;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [ssg_pkg::PADDR_BITS-1:0] paddr  = '0;
    logic [ssg_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [ssg_pkg::PDATA_BITS-1:0] prdata;
    logic                   pready;

    // register shadow
    logic [31:0]            cfg_step   = ssg_pkg::PHASE_STEP_RST;
    logic [31:0]            cfg_offset = ssg_pkg::PHASE_OFFSET_RST;
    logic signed [15:0]     cfg_amp    = ssg_pkg::AMPLITUDE_RST;
    logic signed [15:0]     cfg_level  = ssg_pkg::LEVEL_OFFSET_RST;
    logic [ssg_pkg::LIMIT_BITS-1:0] cfg_limit = ssg_pkg::SAMPLE_LIMIT_RST;

    // oscillator state as predicted
    logic [31:0]            phase_acc  = '0;
    logic [ssg_pkg::LIMIT_BITS-1:0] run_count = '0;

    logic signed [15:0]     sine_lut [TABLE_SIZE];
    logic                   tick_queue [$];
    t_sample                pending_samples [$];
    t_sample                oldest_sample;
    int                     n_accepted  = 0;
    int                     error_count = 0;
    logic                   quiet;

    sine_sample_generator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    // no random idling on either side for a stretch in the middle of the run
    assign quiet = (n_accepted >= 700) && (n_accepted < 1000);

    // quarter wave by rounding half away from zero, the rest by symmetry
    task automatic build_sine_lut();
        int  v;
        real r;
        for (int k = 0; k <= QUARTER; k++) begin
            r = $floor(32767.0 * $sin(HALF_PI * k / QUARTER) + 0.5);
            v = $rtoi(r);
            if (v > 32767) v = 32767;
            sine_lut[k]                  = 16'(v);
            sine_lut[TABLE_SIZE / 2 - k] = 16'(v);
            sine_lut[TABLE_SIZE / 2 + k] = 16'(-v);
            if (k != 0) sine_lut[TABLE_SIZE - k] = 16'(-v);
        end
    endtask

    // one tick of the oscillator: queue the sample it makes, if any
    task automatic synth_tick(input logic restart);
        logic [31:0]        phase_sum;
        logic signed [31:0] product;
        logic signed [31:0] level_sum;
        t_sample            s;
        if (restart) begin
            phase_acc = '0;
            run_count = '0;
        end
        if (run_count < cfg_limit) begin
            phase_sum = phase_acc + cfg_offset;
            product   = sine_lut[phase_sum[31 -: TABLE_BITS]] * cfg_amp;
            level_sum = (product >>> 15) + cfg_level;
            s.value   = level_sum[23:0];
            s.index   = run_count[COUNT_BITS-1:0];
            s.last    = (22'(run_count) + 22'd1) == 22'(cfg_limit);
            pending_samples.push_back(s);
            phase_acc = phase_acc + cfg_step;
            run_count = run_count + 1'b1;
        end
    endtask

    // tick driver: predict on each transfer, then load the next tick or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                synth_tick(i_restart);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (tick_queue.size() != 0 &&
                        (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                    i_valid   <= 1'b1;
                    i_restart <= tick_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_samples.size() == 0) begin
                    $error("unexpected sample: value %0d index %0d last %0b",
                           o_sample_value, o_sample_index, o_last);
                    error_count++;
                end else begin
                    oldest_sample = pending_samples.pop_front();
                    if (o_sample_value !== oldest_sample.value) begin
                        $error("sample_value expected %0d got %0d",
                               oldest_sample.value, o_sample_value);
                        error_count++;
                    end
                    if (o_sample_index !== oldest_sample.index) begin
                        $error("sample_index expected %0d got %0d",
                               oldest_sample.index, o_sample_index);
                        error_count++;
                    end
                    if (o_last !== oldest_sample.last) begin
                        $error("last expected %0b got %0b", oldest_sample.last, o_last);
                        error_count++;
                    end
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // setup and access cycle, shadow follows at the write edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            ssg_pkg::REG_PHASE_STEP:   cfg_step   = value;
            ssg_pkg::REG_PHASE_OFFSET: cfg_offset = value;
            ssg_pkg::REG_AMPLITUDE:    cfg_amp    = value[15:0];
            ssg_pkg::REG_LEVEL_OFFSET: cfg_level  = value[15:0];
            ssg_pkg::REG_SAMPLE_LIMIT: cfg_limit  = value[ssg_pkg::LIMIT_BITS-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reconfigure(input logic [31:0] step, input logic [31:0] offset,
                               input logic [15:0] amp, input logic [15:0] level,
                               input logic [31:0] limit);
        reg_write(ssg_pkg::REG_PHASE_STEP, step);
        reg_write(ssg_pkg::REG_PHASE_OFFSET, offset);
        reg_write(ssg_pkg::REG_AMPLITUDE, {16'd0, amp});
        reg_write(ssg_pkg::REG_LEVEL_OFFSET, {16'd0, level});
        reg_write(ssg_pkg::REG_SAMPLE_LIMIT, limit);
    endtask

    // hold off until every tick is taken and every sample has come, then let the pipe drain
    task automatic wait_drained();
        while (tick_queue.size() != 0 || i_valid || pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_ticks(input logic [15:0] pattern, input int count);
        for (int i = count - 1; i >= 0; i--) tick_queue.push_back(pattern[i]);
    endtask

    function automatic logic [31:0] pick_phase();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(9))
            0:       return 32'd1;
            1:       return 32'd1048576;
            2:       return 32'd2097151;
            default: return 32'($urandom_range(2, 300));
        endcase
    endfunction

    // main sequence
    initial begin
        int          useful_total;
        int          phase_useful;
        int          gen_count;
        logic [31:0] limit;
        logic        r;
        build_sine_lut();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, restart at the start and in the middle of a run
        push_ticks(16'b100010, 6);
        wait_drained();

        // short run: last flag, ticks past the end, restart after the end
        reconfigure(32'h4000_0000, 32'h2000_0000, 16'h0100, 16'h0000, 32'd3);
        push_ticks(16'b1000010, 7);
        wait_drained();

        // positive extremes, full phase wrap, one-sample runs
        reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 32'd1);
        push_ticks(16'b101, 3);
        wait_drained();

        // negative extremes across the four quarter points
        reconfigure(32'h4000_0000, 32'h0000_0000, 16'h8000, 16'h8000, 32'd4);
        push_ticks(16'b1000, 4);
        wait_drained();

        // zero limit: nothing comes out, restart or not
        reg_write(ssg_pkg::REG_SAMPLE_LIMIT, 32'd0);
        push_ticks(16'b10, 2);
        wait_drained();

        // writes to unmapped indexes must leave every register alone
        reg_write(ssg_pkg::REG_SAMPLE_LIMIT, 32'd2);
        reg_write(REG_SPARE_5, 32'd0);
        reg_write(REG_SPARE_6, 32'd0);
        reg_write(REG_SPARE_7, 32'hFFFF_FFFF);
        push_ticks(16'b10, 2);
        wait_drained();

        // random phases of restart-led runs, one setting per phase
        useful_total = 0;
        while (useful_total < RANDOM_TARGET) begin
            limit = pick_limit();
            reconfigure(pick_phase(), pick_phase(), pick_q88(), pick_q88(), limit);
            tick_queue.push_back(1'b1);
            gen_count    = 1;
            phase_useful = 1;
            while (phase_useful < PHASE_SAMPLES) begin
                if (gen_count >= limit) r = ($urandom_range(9) < 8);
                else                    r = ($urandom_range(99) < 3);
                tick_queue.push_back(r);
                if (r) gen_count = 0;
                if (gen_count < limit) begin
                    gen_count++;
                    phase_useful++;
                end
            end
            useful_total += phase_useful;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb_sine_sample_generator_core: clean");
        end else begin
            $display("tb_sine_sample_generator_core: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("tb_sine_sample_generator_core: errors");
        $finish;
    end

endmodule
